### rtl/one_wire_bus_master_core_assert.svh
// assertion macros for the single-wire bus master core
// expects clk and rst_n in the scope of the including module
`ifndef ONE_WIRE_BUS_MASTER_CORE_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OWBM_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("owbm assertion failed");

// next-cycle implication, checked out of reset
`define OWBM_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("owbm assertion failed");

`endif

### rtl/owbm_pkg.sv
// shared types and constants for the single-wire bus master core
// no dependencies
`timescale 1ns / 1ps

package owbm_pkg;

    // field widths
    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int BYTE_W         = 8;
    localparam int BITS_PER_BYTE  = 8;
    localparam int BIT_IDX_W      = 3;
    localparam int TIMER_BITS_DEF = 10;

    // command codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd80;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd400;
    localparam logic [CFG_W-1:0] RST_ONE_LOW       = 10'd1;
    localparam logic [CFG_W-1:0] RST_WRITE_SLOT    = 10'd50;
    localparam logic [CFG_W-1:0] RST_READ_LOW      = 10'd2;
    localparam logic [CFG_W-1:0] RST_READ_TAIL     = 10'd50;

    // command beat
    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] data_byte;
        logic              line_level;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [BYTE_W-1:0] read_data;
    } rsp_t;

    // timing registers as seen by the sequencer
    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait_time;
        logic [CFG_W-1:0] reset_tail_time;
        logic [CFG_W-1:0] one_low_time;
        logic [CFG_W-1:0] write_slot_time;
        logic [CFG_W-1:0] read_low_time;
        logic [CFG_W-1:0] read_tail_time;
    } cfg_regs_t;

    // bus phases
    typedef enum logic [11:0] {
        PH_IDLE       = 12'b0000_0000_0001,
        PH_RST_LOW    = 12'b0000_0000_0010,
        PH_RST_WAIT   = 12'b0000_0000_0100,
        PH_RST_SAMPLE = 12'b0000_0000_1000,
        PH_RST_TAIL   = 12'b0000_0001_0000,
        PH_W1_LOW     = 12'b0000_0010_0000,
        PH_W1_REL     = 12'b0000_0100_0000,
        PH_W0_LOW     = 12'b0000_1000_0000,
        PH_W0_REC     = 12'b0001_0000_0000,
        PH_R_LOW      = 12'b0010_0000_0000,
        PH_R_SAMPLE   = 12'b0100_0000_0000,
        PH_R_TAIL     = 12'b1000_0000_0000
    } phase_t;

endpackage

### rtl/one_wire_bus_master_core.sv
// a command beat is registered in the input stage, then its result beat in the result register
// one command beat per cycle unless a low rsp_ready holds the full result register, each beat is one bus tick
// the rate is set by the single-pass sequencer between input and result registers
// reset: all control and bus state cleared, timing registers back to defaults
// depends on owbm_pkg, owbm_cfg_regs, owbm_sequencer, one_wire_bus_master_core_assert.svh
`timescale 1ns / 1ps

`include "one_wire_bus_master_core_assert.svh"

module one_wire_bus_master_core
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic      s1_valid_reg, s1_valid_next;
    cmd_t      s1_cmd_reg;
    logic      s1_fire;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_t      rsp_reg;
    rsp_t      seq_rsp;
    cfg_regs_t regs;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    owbm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .regs     (regs)
    );

    // input stage moves on when the result register is free or draining
    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_ready)
            s1_valid_next = cmd_valid;
    end

    owbm_sequencer #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_fire),
        .cmd   (s1_cmd_reg),
        .regs  (regs),
        .rsp   (seq_rsp)
    );

    // result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (s1_fire)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
            s1_cmd_reg <= cmd;
        if (s1_fire)
            rsp_reg <= seq_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `OWBM_ASSERT_NOW(a_done_not_busy, rsp_valid && rsp.done_res, !rsp.busy_res)
    `OWBM_ASSERT_NOW(a_drive_in_op, rsp_valid && rsp.drive_low, rsp.busy_res || rsp.done_res)
    `OWBM_ASSERT_NOW(a_empty_stage_ready, !s1_valid_reg, cmd_ready)
    `OWBM_ASSERT_NEXT(a_fire_gives_result, s1_fire, rsp_valid)

endmodule

### rtl/owbm_cfg_regs.sv
// timing register file of the single-wire bus master
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_cfg_regs
    import owbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output cfg_regs_t            regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    // write decode, out-of-range indexes are dropped
    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_RESET_LOW:     regs_next.reset_low_time     = wr_data;
                REG_PRESENCE_WAIT: regs_next.presence_wait_time = wr_data;
                REG_RESET_TAIL:    regs_next.reset_tail_time    = wr_data;
                REG_ONE_LOW:       regs_next.one_low_time       = wr_data;
                REG_WRITE_SLOT:    regs_next.write_slot_time    = wr_data;
                REG_READ_LOW:      regs_next.read_low_time      = wr_data;
                REG_READ_TAIL:     regs_next.read_tail_time     = wr_data;
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.reset_low_time     <= RST_RESET_LOW;
            regs_reg.presence_wait_time <= RST_PRESENCE_WAIT;
            regs_reg.reset_tail_time    <= RST_RESET_TAIL;
            regs_reg.one_low_time       <= RST_ONE_LOW;
            regs_reg.write_slot_time    <= RST_WRITE_SLOT;
            regs_reg.read_low_time      <= RST_READ_LOW;
            regs_reg.read_tail_time     <= RST_READ_TAIL;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

### rtl/owbm_sequencer.sv
// bus phase sequencer: one tick of bus timing per step
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_sequencer
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  cmd_t      cmd,
    input  cfg_regs_t regs,
    output rsp_t      rsp
);

    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIMER_BITS) - 64'd1);

    // clamp a register to the timer range, optionally at least one tick
    function automatic logic [TIMER_BITS-1:0] clamp(input logic [CFG_W-1:0] v,
                                                     input logic min1);
        logic [CW-1:0] w;
        w = CW'(v);
        if (min1 && (w == '0))
            w = CW'(1);
        if (w > TMAX)
            w = TMAX;
        return TIMER_BITS'(w);
    endfunction

    phase_t                 phase_reg, phase_next;
    logic [TIMER_BITS-1:0]  tick_reg, tick_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    logic                   pres_reg, pres_next;
    logic [BYTE_W-1:0]      recv_reg, recv_next;

    logic [TIMER_BITS-1:0]  dur;
    logic [TIMER_BITS-1:0]  tick_inc;
    logic [TIMER_BITS-1:0]  rst_tail_dur;
    logic [TIMER_BITS-1:0]  rd_tail_dur;
    logic [BIT_IDX_W-1:0]   bit_inc;
    logic                   last_bit;
    logic                   drive;
    logic                   done;

    assign rst_tail_dur = clamp(regs.reset_tail_time, 1'b0);
    assign rd_tail_dur  = clamp(regs.read_tail_time, 1'b0);

    // one tick of the bus timing
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        recv_next  = recv_reg;
        drive      = 1'b0;
        done       = 1'b0;
        dur        = TIMER_BITS'(1);
        tick_inc   = '0;
        bit_inc    = '0;
        last_bit   = 1'b0;

        // command start while idle, this beat is already the first tick
        if (phase_reg == PH_IDLE && cmd.action != ACT_TICK)
        begin
            tick_next = '0;
            bit_next  = '0;
            case (cmd.action)
                ACT_RESET:
                begin
                    phase_next = PH_RST_LOW;
                end
                ACT_WRITE:
                begin
                    shift_next = cmd.data_byte;
                    phase_next = cmd.data_byte[0] ? PH_W1_LOW : PH_W0_LOW;
                end
                default:
                begin
                    shift_next = '0;
                    phase_next = PH_R_LOW;
                end
            endcase
        end

        if (phase_next != PH_IDLE)
        begin
            drive = (phase_next == PH_RST_LOW) || (phase_next == PH_W1_LOW) ||
                    (phase_next == PH_W0_LOW) || (phase_next == PH_R_LOW);
            if (phase_next == PH_RST_SAMPLE)
                pres_next = ~cmd.line_level;
            if (phase_next == PH_R_SAMPLE && cmd.line_level)
                shift_next[bit_next] = 1'b1;

            // duration of the current phase
            case (phase_next)
                PH_RST_LOW:  dur = clamp(regs.reset_low_time, 1'b1);
                PH_RST_WAIT: dur = clamp(regs.presence_wait_time, 1'b1);
                PH_RST_TAIL: dur = rst_tail_dur;
                PH_W1_LOW:   dur = clamp(regs.one_low_time, 1'b1);
                PH_W1_REL:   dur = clamp(regs.write_slot_time, 1'b1);
                PH_W0_LOW:   dur = clamp(regs.write_slot_time, 1'b1);
                PH_R_LOW:    dur = clamp(regs.read_low_time, 1'b1);
                PH_R_TAIL:   dur = rd_tail_dur;
                default:     dur = TIMER_BITS'(1);
            endcase

            tick_inc  = tick_next + 1'b1;
            tick_next = tick_inc;
            bit_inc   = bit_next + 1'b1;
            last_bit  = (bit_next == BIT_IDX_W'(BITS_PER_BYTE - 1));

            // phase over, move on
            if (tick_inc == '0 || tick_inc >= dur)
            begin
                tick_next = '0;
                case (phase_next)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT: phase_next = PH_RST_SAMPLE;
                    PH_RST_SAMPLE:
                    begin
                        if (rst_tail_dur != '0)
                            phase_next = PH_RST_TAIL;
                        else
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_RST_TAIL:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_W1_LOW:   phase_next = PH_W1_REL;
                    PH_W0_LOW:   phase_next = PH_W0_REC;
                    PH_W1_REL, PH_W0_REC:
                    begin
                        if (last_bit)
                        begin
                            phase_next = PH_IDLE;
                            bit_next   = '0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_inc;
                            phase_next = shift_next[bit_inc] ? PH_W1_LOW : PH_W0_LOW;
                        end
                    end
                    PH_R_LOW:    phase_next = PH_R_SAMPLE;
                    PH_R_SAMPLE, PH_R_TAIL:
                    begin
                        if (phase_next == PH_R_SAMPLE && rd_tail_dur != '0)
                            phase_next = PH_R_TAIL;
                        else if (last_bit)
                        begin
                            recv_next  = shift_next;
                            phase_next = PH_IDLE;
                            bit_next   = '0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_inc;
                            phase_next = PH_R_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    // result of this tick
    always_comb
    begin
        rsp.drive_low = drive;
        rsp.busy_res  = (phase_next != PH_IDLE);
        rsp.done_res  = done;
        rsp.presence  = pres_next;
        rsp.read_data = recv_next;
    end

    // bus state, advances once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            recv_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            recv_reg  <= recv_next;
        end
    end

endmodule
